// ===== rtl/mm_pkg.sv =====
package mm_pkg;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int VAL_W       = 32;
  localparam int CFG_W       = 4;

  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_COLS_A = 2'd1;
  localparam logic [1:0] REG_ROWS_B = 2'd2;
  localparam logic [1:0] REG_COLS_B = 2'd3;

  // One multiply-accumulate step as it moves down the datapath
  typedef struct packed {
    logic valid;
    logic first;
    logic lastk;
  } mac_ctl_t;

  // Clamp a configured dimension into 1..lim
  function automatic logic [CFG_W-1:0] eff_dim(logic [CFG_W-1:0] v, logic [CFG_W-1:0] lim);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > lim) begin
      r = lim;
    end
    return r;
  endfunction

endpackage

// ===== rtl/mm_store.sv =====
module mm_store #(
  parameter int IW = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [IW-1:0]             wr_row,
  input  logic [IW-1:0]             wr_col,
  input  logic [mm_pkg::VAL_W-1:0]  wr_data,
  input  logic [IW-1:0]             rd_row,
  input  logic [IW-1:0]             rd_col,
  output logic [mm_pkg::VAL_W-1:0]  rd_data
);

  localparam int DEPTH = 2 ** (2 * IW);

  logic [mm_pkg::VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]         valid;
  logic [2*IW-1:0]          wr_addr;
  logic [2*IW-1:0]          rd_addr;

  assign wr_addr = {wr_row, wr_col};
  assign rd_addr = {rd_row, rd_col};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

// ===== rtl/mm_mac.sv =====
module mm_mac #(
  parameter int IW = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mm_pkg::mac_ctl_t          ctl,
  input  logic [mm_pkg::VAL_W-1:0]  a_data,
  input  logic [mm_pkg::VAL_W-1:0]  b_data,
  output logic                      done,
  output logic [mm_pkg::VAL_W-1:0]  value
);

  localparam int PROD_W = 2 * mm_pkg::VAL_W;
  localparam int ACC_W  = PROD_W + IW;

  mm_pkg::mac_ctl_t         ctl_s1;
  mm_pkg::mac_ctl_t         ctl_s2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-48:0]        top_bits;

  // Align control with the registered store read, then with the product
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s1 <= '0;
      ctl_s2 <= '0;
      done   <= 1'b0;
    end else begin
      ctl_s1 <= ctl;
      ctl_s2 <= ctl_s1;
      done   <= ctl_s2.valid && ctl_s2.lastk;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(a_data) * $signed(b_data);
  end

  always_ff @(posedge clk) begin
    if (ctl_s2.valid) begin
      if (ctl_s2.first) begin
        acc <= ACC_W'(prod);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  // Drop 16 fraction bits (floor), saturate to 32 bits
  assign top_bits = acc[ACC_W-1:47];

  always_comb begin
    if (top_bits == '0 || top_bits == '1) begin
      value = acc[47:16];
    end else if (acc[ACC_W-1]) begin
      value = {1'b1, {(mm_pkg::VAL_W-1){1'b0}}};
    end else begin
      value = {1'b0, {(mm_pkg::VAL_W-1){1'b1}}};
    end
  end

endmodule

// ===== rtl/mm_seq.sv =====
module mm_seq #(
  parameter int LIM = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mm_pkg::CFG_W-1:0]      rows_a,
  input  logic [mm_pkg::CFG_W-1:0]      cols_a,
  input  logic [mm_pkg::CFG_W-1:0]      rows_b,
  input  logic [mm_pkg::CFG_W-1:0]      cols_b,
  input  logic                          mac_done,
  input  logic [mm_pkg::VAL_W-1:0]      mac_value,
  output mm_pkg::mac_ctl_t              ctl,
  output logic [$clog2(LIM)-1:0]        a_row,
  output logic [$clog2(LIM)-1:0]        a_col,
  output logic [$clog2(LIM)-1:0]        b_row,
  output logic [$clog2(LIM)-1:0]        b_col,
  output logic                          idle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_row,
  output logic [2:0]                    out_col,
  output logic [mm_pkg::VAL_W-1:0]      out_value,
  output logic                          out_last,
  output logic                          out_err
);

  localparam int IW = $clog2(LIM);
  localparam int DW = $clog2(LIM + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_PUSH  = 4'b1000
  } state_t;

  state_t         state;
  logic [IW-1:0]  i;
  logic [IW-1:0]  j;
  logic [IW-1:0]  k;
  logic [DW-1:0]  m;
  logic [DW-1:0]  n;
  logic [DW-1:0]  inner;
  logic           err;
  logic           k_last;
  logic           i_last;
  logic           j_last;
  logic           out_free;
  logic [DW-1:0]  eff_cols_a;
  logic [DW-1:0]  eff_rows_b;

  assign eff_cols_a = DW'(mm_pkg::eff_dim(cols_a, mm_pkg::CFG_W'(LIM)));
  assign eff_rows_b = DW'(mm_pkg::eff_dim(rows_b, mm_pkg::CFG_W'(LIM)));

  assign k_last   = DW'(k) == inner - DW'(1);
  assign i_last   = DW'(i) == m - DW'(1);
  assign j_last   = DW'(j) == n - DW'(1);
  assign out_free = !out_valid || out_ready;
  assign idle     = state == ST_IDLE;

  assign ctl.valid = state == ST_ISSUE;
  assign ctl.first = k == '0;
  assign ctl.lastk = k_last;
  assign a_row     = i;
  assign a_col     = k;
  assign b_row     = k;
  assign b_col     = j;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      m     <= '0;
      n     <= '0;
      inner <= '0;
      err   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            m     <= DW'(mm_pkg::eff_dim(rows_a, mm_pkg::CFG_W'(LIM)));
            n     <= DW'(mm_pkg::eff_dim(cols_b, mm_pkg::CFG_W'(LIM)));
            inner <= eff_cols_a;
            err   <= eff_cols_a != eff_rows_b;
            i     <= '0;
            j     <= '0;
            k     <= '0;
            state <= (eff_cols_a != eff_rows_b) ? ST_PUSH : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k_last) begin
            k     <= '0;
            state <= ST_DRAIN;
          end else begin
            k <= k + IW'(1);
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            if (i_last && j_last) begin
              state <= ST_IDLE;
            end else begin
              state <= err ? ST_PUSH : ST_ISSUE;
              if (j_last) begin
                j <= '0;
                i <= i + IW'(1);
              end else begin
                j <= j + IW'(1);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: load on push, drop on transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_PUSH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUSH && out_free) begin
      out_row   <= 3'(i);
      out_col   <= 3'(j);
      out_value <= err ? '0 : mac_value;
      out_last  <= i_last && j_last;
      out_err   <= err;
    end
  end

endmodule

// ===== rtl/matrix_multiply_core.sv =====
// Load items (A or B element) are taken only while idle and may follow back to back.
// A start item emits rows_a x cols_b results; each is built by one shared 32x32
// multiplier and accumulator walking the inner dimension (inner = effective cols_a).
// A dimension mismatch gives one zero result a cycle while m_tready stays high.
// Ready returns once the last result is loaded. Reset (rst, synchronous) restores
// all dimensions to 3 and clears both element stores at once through per-entry valid bits.
module matrix_multiply_core #(
  parameter int MAX_DIM = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mm_pkg::IN_TDATA_W-1:0]   s_tdata,   // elem_row, elem_col, elem_value, pad
  input  logic [1:0]                      s_tuser,   // req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mm_pkg::OUT_TDATA_W-1:0]  m_tdata,   // out_row, out_col, out_value, pad
  output logic                            m_tlast,
  output logic                            m_tuser,   // dim_error
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [mm_pkg::CFG_W-1:0]        cfg_data
);

  localparam int LIM = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int IW  = $clog2(LIM);

  logic [mm_pkg::CFG_W-1:0] rows_a;
  logic [mm_pkg::CFG_W-1:0] cols_a;
  logic [mm_pkg::CFG_W-1:0] rows_b;
  logic [mm_pkg::CFG_W-1:0] cols_b;

  logic                     in_fire;
  logic [2:0]               elem_row;
  logic [2:0]               elem_col;
  logic [mm_pkg::VAL_W-1:0] elem_value;
  logic                     in_range;
  logic                     wr_a;
  logic                     wr_b;
  logic                     start;

  mm_pkg::mac_ctl_t         ctl;
  logic [IW-1:0]            a_row;
  logic [IW-1:0]            a_col;
  logic [IW-1:0]            b_row;
  logic [IW-1:0]            b_col;
  logic [mm_pkg::VAL_W-1:0] a_data;
  logic [mm_pkg::VAL_W-1:0] b_data;
  logic                     mac_done;
  logic [mm_pkg::VAL_W-1:0] mac_value;
  logic                     idle;
  logic [2:0]               out_row;
  logic [2:0]               out_col;
  logic [mm_pkg::VAL_W-1:0] out_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= mm_pkg::CFG_W'(3);
      cols_a <= mm_pkg::CFG_W'(3);
      rows_b <= mm_pkg::CFG_W'(3);
      cols_b <= mm_pkg::CFG_W'(3);
    end else if (cfg_valid) begin
      case (cfg_index)
        mm_pkg::REG_ROWS_A: rows_a <= cfg_data;
        mm_pkg::REG_COLS_A: cols_a <= cfg_data;
        mm_pkg::REG_ROWS_B: rows_b <= cfg_data;
        mm_pkg::REG_COLS_B: cols_b <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_tready   = idle;
  assign in_fire    = s_tvalid && s_tready;
  assign elem_row   = s_tdata[2:0];
  assign elem_col   = s_tdata[5:3];
  assign elem_value = s_tdata[37:6];
  assign in_range   = (4'(elem_row) < 4'(LIM)) && (4'(elem_col) < 4'(LIM));
  assign wr_a       = in_fire && in_range && s_tuser == mm_pkg::REQ_LOAD_A;
  assign wr_b       = in_fire && in_range && s_tuser == mm_pkg::REQ_LOAD_B;
  assign start      = in_fire && s_tuser == mm_pkg::REQ_START;

  mm_store #(.IW(IW)) u_store_a (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_a),
    .wr_row  (elem_row[IW-1:0]),
    .wr_col  (elem_col[IW-1:0]),
    .wr_data (elem_value),
    .rd_row  (a_row),
    .rd_col  (a_col),
    .rd_data (a_data)
  );

  mm_store #(.IW(IW)) u_store_b (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_b),
    .wr_row  (elem_row[IW-1:0]),
    .wr_col  (elem_col[IW-1:0]),
    .wr_data (elem_value),
    .rd_row  (b_row),
    .rd_col  (b_col),
    .rd_data (b_data)
  );

  mm_mac #(.IW(IW)) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .a_data (a_data),
    .b_data (b_data),
    .done   (mac_done),
    .value  (mac_value)
  );

  mm_seq #(.LIM(LIM)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .rows_a    (rows_a),
    .cols_a    (cols_a),
    .rows_b    (rows_b),
    .cols_b    (cols_b),
    .mac_done  (mac_done),
    .mac_value (mac_value),
    .ctl       (ctl),
    .a_row     (a_row),
    .a_col     (a_col),
    .b_row     (b_row),
    .b_col     (b_col),
    .idle      (idle),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (m_tlast),
    .out_err   (m_tuser)
  );

  assign m_tdata = {2'b00, out_value, out_col, out_row};

endmodule

// ===== rtl/mm_checker.sv =====
module mm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [1:0]                      s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mm_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                            m_tlast,
  input logic                            m_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("result changed while stalled");

  // A start transaction makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == mm_pkg::REQ_START |=> !s_tready)
    else $error("input ready right after start");

  // Results are produced only while a product is in progress
  a_rose_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while idle");

  // A mismatch result carries a zero value and zero padding
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[39:6] == '0)
    else $error("nonzero value on dimension error");

endmodule

bind matrix_multiply_core mm_checker u_mm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// ===== bench/matrix_multiply_core_tb.sv =====
module matrix_multiply_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAT_N = 8;          // row pitch of the element stores
  localparam int DIM_LIM = 8;        // largest effective dimension
  localparam int SETTLE = 40;        // quiet cycles before a register write and at the end
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [1:0] REG_ORDER [4] = '{mm_pkg::REG_ROWS_A, mm_pkg::REG_COLS_A,
                                           mm_pkg::REG_ROWS_B, mm_pkg::REG_COLS_B};
  localparam logic signed [79:0] Q_MAX = 80'sh7FFFFFFF;
  localparam logic signed [79:0] Q_MIN = -80'sh80000000;

  typedef struct {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
    logic        err;
  } elem_t;

  typedef enum logic [1:0] {ST_DIMS, ST_ITEM} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [1:0]  req;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic [3:0]  ra, ca, rb, cb;
    bit          fixed;
    logic [31:0] fixed_val;
    logic        fixed_err;
  } step_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [mm_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic [1:0]                     s_tuser = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [mm_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                           m_tlast;
  logic                           m_tuser;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [1:0]                     cfg_index = '0;
  logic [mm_pkg::CFG_W-1:0]       cfg_data = '0;

  // Shadow of the block: element stores and dimension registers
  logic [31:0] mat_a [MAT_N*MAT_N];
  logic [31:0] mat_b [MAT_N*MAT_N];
  logic [3:0]  dim_reg [4];
  elem_t       pending [$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  items_accepted = 0;
  bit  quiet = 1'b0;

  matrix_multiply_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int clamp_dim(logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > DIM_LIM) return DIM_LIM;
    return int'(v);
  endfunction

  // Walk C in row-major order; sums are exact, then floored to Q16.16 and saturated
  function automatic void predict_product(bit fixed, logic [31:0] fixed_val, logic fixed_err);
    int m, n, inner;
    logic err;
    logic signed [79:0] acc, q;
    elem_t e;
    m = clamp_dim(dim_reg[mm_pkg::REG_ROWS_A]);
    n = clamp_dim(dim_reg[mm_pkg::REG_COLS_B]);
    inner = clamp_dim(dim_reg[mm_pkg::REG_COLS_A]);
    err = (inner != clamp_dim(dim_reg[mm_pkg::REG_ROWS_B]));
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = '0;
        for (int k = 0; k < inner; k++) begin
          acc += $signed(mat_a[i*MAT_N+k]) * $signed(mat_b[k*MAT_N+j]);
        end
        q = acc >>> 16;
        e.row = 3'(i);
        e.col = 3'(j);
        if (err) e.value = '0;
        else if (q > Q_MAX) e.value = 32'h7FFFFFFF;
        else if (q < Q_MIN) e.value = 32'h80000000;
        else e.value = q[31:0];
        e.last = (i == m - 1) && (j == n - 1);
        e.err = err;
        if (fixed) begin
          e.value = fixed_val;
          e.err = fixed_err;
        end
        pending.push_back(e);
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 50) $display("%0t: %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic send_item(logic [1:0] req, logic [2:0] row, logic [2:0] col, logic [31:0] val,
                           bit fixed, logic [31:0] fixed_val, logic fixed_err);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {2'b00, val, col, row};
    do @(posedge clk); while (!s_tready);
    // every 3-bit index is inside the store when MAX_DIM is 8
    case (req)
      mm_pkg::REQ_LOAD_A: mat_a[row*MAT_N+col] = val;
      mm_pkg::REQ_LOAD_B: mat_b[row*MAT_N+col] = val;
      mm_pkg::REQ_START:  predict_product(fixed, fixed_val, fixed_err);
      default: ;
    endcase
    if (req != REQ_UNKNOWN) items_accepted++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_dims(logic [3:0] ra, logic [3:0] ca, logic [3:0] rb, logic [3:0] cb);
    logic [3:0] vals [4];
    vals = '{ra, ca, rb, cb};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      dim_reg[REG_ORDER[i]] = vals[i];
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h7FFFF) - 32'h40000;  // about +-4.0
    endcase
  endfunction

  task automatic send_noise();
    if ($urandom_range(0, 1) == 0)
      send_item(REQ_UNKNOWN, 3'($urandom), 3'($urandom), $urandom(), 1'b0, '0, 1'b0);
    else
      send_item(2'($urandom_range(0, 1)), 3'($urandom), 3'($urandom), rand_q16(), 1'b0, '0,
                1'b0);
  endtask

  function automatic step_t t_load(logic [1:0] req, logic [2:0] row, logic [2:0] col,
                                   logic [31:0] val);
    return '{kind: ST_ITEM, req: req, row: row, col: col, value: val, ra: 4'd0, ca: 4'd0,
             rb: 4'd0, cb: 4'd0, fixed: 1'b0, fixed_val: '0, fixed_err: 1'b0};
  endfunction

  function automatic step_t t_dims(logic [3:0] ra, logic [3:0] ca, logic [3:0] rb,
                                   logic [3:0] cb);
    return '{kind: ST_DIMS, req: mm_pkg::REQ_LOAD_A, row: 3'd0, col: 3'd0, value: '0, ra: ra,
             ca: ca, rb: rb, cb: cb, fixed: 1'b0, fixed_val: '0, fixed_err: 1'b0};
  endfunction

  function automatic step_t t_start(bit fixed, logic [31:0] fval, logic ferr);
    return '{kind: ST_ITEM, req: mm_pkg::REQ_START, row: 3'd0, col: 3'd0, value: '0, ra: 4'd0,
             ca: 4'd0, rb: 4'd0, cb: 4'd0, fixed: fixed, fixed_val: fval, fixed_err: ferr};
  endfunction

  // Result checker
  always @(posedge clk) begin
    elem_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[37:6], '0);
      end else begin
        want = pending.pop_front();
        if (m_tdata[2:0] != want.row)
          report_mismatch("out_row", 32'(m_tdata[2:0]), 32'(want.row));
        if (m_tdata[5:3] != want.col)
          report_mismatch("out_col", 32'(m_tdata[5:3]), 32'(want.col));
        if (m_tdata[37:6] !== want.value)
          report_mismatch("out_value", m_tdata[37:6], want.value);
        if (m_tlast !== want.last) report_mismatch("last", 32'(m_tlast), 32'(want.last));
        if (m_tuser !== want.err) report_mismatch("dim_error", 32'(m_tuser), 32'(want.err));
      end
    end
  end

  // Result sink with random back-pressure
  initial begin
    int stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready && !rst));
    end
  end

  initial begin
    step_t plan [$];
    logic [3:0] ra, ca, rb, cb;
    int pick, random_start;
    bit thin;

    foreach (mat_a[i]) begin
      mat_a[i] = '0;
      mat_b[i] = '0;
    end
    foreach (dim_reg[i]) dim_reg[i] = 4'd3;

    plan.push_back(t_start(1'b1, 32'h0, 1'b0));            // stores clear after reset
    plan.push_back(t_dims(4'd1, 4'd1, 4'd1, 4'd1));
    plan.push_back(t_load(mm_pkg::REQ_LOAD_A, 3'd0, 3'd0, 32'h7FFFFFFF));
    plan.push_back(t_load(mm_pkg::REQ_LOAD_B, 3'd0, 3'd0, 32'h7FFFFFFF));
    plan.push_back(t_start(1'b1, 32'h7FFFFFFF, 1'b0));     // positive saturation
    plan.push_back(t_load(mm_pkg::REQ_LOAD_A, 3'd0, 3'd0, 32'h80000000));
    plan.push_back(t_start(1'b1, 32'h80000000, 1'b0));     // negative saturation
    plan.push_back(t_load(mm_pkg::REQ_LOAD_B, 3'd0, 3'd0, 32'h80000000));
    plan.push_back(t_start(1'b1, 32'h7FFFFFFF, 1'b0));
    plan.push_back(t_load(mm_pkg::REQ_LOAD_A, 3'd0, 3'd0, 32'hFFFFFFFF));
    plan.push_back(t_load(mm_pkg::REQ_LOAD_B, 3'd0, 3'd0, 32'h00000001));
    plan.push_back(t_start(1'b1, 32'hFFFFFFFF, 1'b0));     // floor toward minus infinity
    plan.push_back(t_load(REQ_UNKNOWN, 3'd7, 3'd7, 32'hFFFFFFFF));
    plan.push_back(t_start(1'b1, 32'hFFFFFFFF, 1'b0));     // unknown request left stores alone
    plan.push_back(t_dims(4'd2, 4'd2, 4'd3, 4'd2));
    plan.push_back(t_start(1'b1, 32'h0, 1'b1));            // inner dimension mismatch
    plan.push_back(t_dims(4'd0, 4'd15, 4'd8, 4'd15));      // zero and oversize dimensions
    plan.push_back(t_load(mm_pkg::REQ_LOAD_A, 3'd0, 3'd7, 32'h00018000));
    plan.push_back(t_load(mm_pkg::REQ_LOAD_B, 3'd7, 3'd7, 32'hFFFF0000));
    plan.push_back(t_load(mm_pkg::REQ_LOAD_B, 3'd7, 3'd0, 32'h00020000));
    plan.push_back(t_start(1'b0, '0, 1'b0));
    plan.push_back(t_dims(4'd8, 4'd8, 4'd8, 4'd8));
    plan.push_back(t_load(mm_pkg::REQ_LOAD_A, 3'd7, 3'd7, 32'h7FFFFFFF));
    plan.push_back(t_load(mm_pkg::REQ_LOAD_A, 3'd7, 3'd0, 32'h80000000));
    plan.push_back(t_start(1'b0, '0, 1'b0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ST_DIMS) begin
        drain();
        write_dims(plan[i].ra, plan[i].ca, plan[i].rb, plan[i].cb);
      end else begin
        send_item(plan[i].req, plan[i].row, plan[i].col, plan[i].value, plan[i].fixed,
                  plan[i].fixed_val, plan[i].fixed_err);
      end
    end

    // Random part: reconfigure, fill the operands, start; some phases keep the sizes
    random_start = items_accepted;
    ra = dim_reg[mm_pkg::REG_ROWS_A];
    ca = dim_reg[mm_pkg::REG_COLS_A];
    rb = dim_reg[mm_pkg::REG_ROWS_B];
    cb = dim_reg[mm_pkg::REG_COLS_B];
    while (items_accepted - random_start < 80 || results_seen < 48) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 11);
        ra = 4'($urandom_range(1, 3));
        cb = 4'($urandom_range(1, 3));
        ca = 4'($urandom_range(1, 4));
        rb = ca;
        if (pick == 0) begin
          ra = 4'($urandom_range(5, 8));
          ca = 4'($urandom_range(5, 8));
          rb = ca;
          cb = 4'($urandom_range(5, 8));
        end else if (pick == 1) begin
          rb = 4'($urandom_range(0, 15));
        end else if (pick == 2) begin
          ra = 4'd0;
          ca = 4'($urandom_range(9, 15));
          rb = 4'($urandom_range(8, 15));
          cb = 4'($urandom_range(0, 1));
        end
        drain();
        write_dims(ra, ca, rb, cb);
      end
      thin = (clamp_dim(ra) * clamp_dim(ca) > 16);
      for (int i = 0; i < clamp_dim(ra); i++) begin
        for (int k = 0; k < clamp_dim(ca); k++) begin
          if (thin ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 4) != 0))
            send_item(mm_pkg::REQ_LOAD_A, 3'(i), 3'(k), rand_q16(), 1'b0, '0, 1'b0);
          if ($urandom_range(0, 15) == 0) send_noise();
        end
      end
      thin = (clamp_dim(rb) * clamp_dim(cb) > 16);
      for (int k = 0; k < clamp_dim(rb); k++) begin
        for (int j = 0; j < clamp_dim(cb); j++) begin
          if (thin ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 4) != 0))
            send_item(mm_pkg::REQ_LOAD_B, 3'(k), 3'(j), rand_q16(), 1'b0, '0, 1'b0);
          if ($urandom_range(0, 15) == 0) send_noise();
        end
      end
      send_item(mm_pkg::REQ_START, 3'd0, 3'd0, '0, 1'b0, '0, 1'b0);
      if ($urandom_range(0, 3) == 0) send_item(mm_pkg::REQ_START, 3'($urandom), 3'($urandom),
                                               $urandom(), 1'b0, '0, 1'b0);
    end

    quiet = 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
